// ----- sv/arc_pkg.sv -----
// ----------------------------------------------------------------------------
// arc_pkg - shared types and constants for the ARP responder and cache
// Field widths, ARP header constants, action codes and the request/response
// structs between the sequencer and the cache search engine.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  typedef logic [IP_W-1:0]  ip_t;
  typedef logic [MAC_W-1:0] mac_t;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_MAC     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBNET_MASK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATEWAY_IP  = 8'd3;

  // ARP header values
  localparam logic [15:0] ARP_OPER_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OPER_REPLY   = 16'd2;
  localparam logic [15:0] ARP_HTYPE_ETH    = 16'd1;
  localparam logic [15:0] ARP_PTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  ARP_HLEN_ETH     = 8'd6;
  localparam logic [7:0]  ARP_PLEN_IPV4    = 8'd4;

  // result codes
  typedef enum logic [2:0] {
    ACT_ABSORB = 3'd0,
    ACT_REPLY  = 3'd1,
    ACT_UNSUP  = 3'd2,
    ACT_HIT    = 3'd3,
    ACT_MISS   = 3'd4
  } action_t;

  localparam logic [1:0] FOP_NONE  = 2'd0;
  localparam logic [1:0] FOP_QUERY = 2'd1;
  localparam logic [1:0] FOP_REPLY = 2'd2;

  // stream payload widths
  localparam int IN_TDATA_W  = 256;
  localparam int OUT_FIELDS_W = 3 + 2 + MAC_W + IP_W + MAC_W;
  localparam int OUT_TDATA_W = 136;

  typedef struct packed {
    logic start;  // one-cycle pulse
    logic learn;  // 1: search then write, 0: search only
    ip_t  key;
    mac_t mac;
  } cache_req_t;

  typedef struct packed {
    logic done;   // one-cycle pulse
    logic hit;
    mac_t mac;
  } cache_rsp_t;

endpackage

// ----- sv/arc_cache.sv -----
// ----------------------------------------------------------------------------
// arc_cache - IPv4 to MAC cache with a sequential search engine
// One entry memory with a registered read port is scanned one slot a cycle
// by a single shared IP comparator; the lowest valid match wins. A learn
// operation then overwrites the match or the round-robin replacement slot.
// ----------------------------------------------------------------------------
module arc_cache
  import arc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cache_req_t req,
  output cache_rsp_t rsp
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(CACHE_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE
  } state_t;

  state_t                   state_r;
  logic [CNT_W-1:0]         issue_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  logic                     pend_r;
  logic                     rd_valid_r;
  logic [IDX_W-1:0]         slot_r;
  logic [IDX_W-1:0]         ptr_r;
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic                     done_r;
  logic                     hit_r;
  mac_t                     mac_out_r;
  ip_t                      key_r;
  mac_t                     mac_r;
  logic                     learn_r;

  logic [IP_W+MAC_W-1:0] mem [CACHE_ENTRIES];
  logic [IP_W+MAC_W-1:0] rd_data_r;

  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  logic             match;
  logic [IDX_W-1:0] ptr_nxt;

  assign rd_idx  = issue_r[IDX_W-1:0];
  assign rd_en   = (state_r == S_SCAN) && (issue_r < N_CNT);
  assign match   = pend_r && rd_valid_r && (rd_data_r[IP_W+MAC_W-1:MAC_W] == key_r);
  assign ptr_nxt = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      mem[slot_r] <= {key_r, mac_r};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      issue_r    <= '0;
      cmp_idx_r  <= '0;
      pend_r     <= 1'b0;
      rd_valid_r <= 1'b0;
      slot_r     <= '0;
      ptr_r      <= '0;
      valid_r    <= '0;
      done_r     <= 1'b0;
      hit_r      <= 1'b0;
      mac_out_r  <= '0;
      key_r      <= '0;
      mac_r      <= '0;
      learn_r    <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            key_r   <= req.key;
            mac_r   <= req.mac;
            learn_r <= req.learn;
            issue_r <= '0;
            pend_r  <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read of slot n overlaps the compare of slot n-1
          pend_r <= rd_en;
          if (rd_en) begin
            issue_r    <= issue_r + 1'b1;
            rd_valid_r <= valid_r[rd_idx];
            cmp_idx_r  <= rd_idx;
          end
          if (match) begin
            hit_r     <= 1'b1;
            slot_r    <= cmp_idx_r;
            mac_out_r <= rd_data_r[MAC_W-1:0];
            if (learn_r) begin
              state_r <= S_WRITE;
            end else begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end
          end else if (pend_r && (cmp_idx_r == LAST_IDX)) begin
            hit_r  <= 1'b0;
            slot_r <= ptr_r;
            if (learn_r) begin
              ptr_r   <= ptr_nxt;
              state_r <= S_WRITE;
            end else begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        S_WRITE: begin
          valid_r[slot_r] <= 1'b1;
          done_r          <= 1'b1;
          state_r         <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp = '{done: done_r, hit: hit_r, mac: mac_out_r};

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= LAST_IDX)
    else $error("replacement pointer beyond last slot");

  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == S_SCAN) || ($past(state_r) == S_WRITE))
    else $error("response without a search");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> done_r && valid_r[$past(slot_r)])
    else $error("learn did not complete");
`endif

endmodule

// ----- sv/arp_responder_and_cache.sv -----
// Sequence: decode, then for a learn or a resolve a wait on the cache search
// engine, then emit; an opcode other than request or reply goes from decode
// straight to emit. Throughput: one transaction at a time; the scan of one
// slot per cycle through the shared IP comparator sets the interval.
// Reset: synchronous, active low; clears control and result registers, cache valid bits and the
// replacement pointer. No clearing pass is needed.
// ----------------------------------------------------------------------------
// arp_responder_and_cache - ARP engine for one IPv4 Ethernet interface
// Decodes received ARP packets and resolve requests, drives the cache search
// engine and returns one result per input transaction.
// ----------------------------------------------------------------------------
module arp_responder_and_cache
  import arc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // oper, htype, ptype, hlen, plen, sender_mac, sender_ip, target_ip,
  // eth_src_mac, lookup_ip
  input  logic [IN_TDATA_W-1:0] in_tdata,
  // kind
  input  logic                  in_tuser,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // action, frame_oper, frame_target_mac, frame_target_ip, resolved_mac, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  typedef enum logic [1:0] {
    T_IDLE,
    T_DECODE,
    T_WAIT,
    T_EMIT
  } state_t;

  state_t state_r;

  // configuration (own MAC is inserted by the frame builder, not stored here)
  ip_t own_ip_r;
  ip_t subnet_mask_r;
  ip_t gateway_ip_r;

  // captured transaction
  logic        kind_r;
  logic [15:0] oper_r;
  logic [15:0] htype_r;
  logic [15:0] ptype_r;
  logic [7:0]  hlen_r;
  logic [7:0]  plen_r;
  mac_t        sender_mac_r;
  ip_t         sender_ip_r;
  ip_t         target_ip_r;
  mac_t        eth_src_mac_r;
  ip_t         lookup_ip_r;

  ip_t     hop_r;
  action_t res_action_r;
  logic [1:0] res_fop_r;
  mac_t    res_tmac_r;
  ip_t     res_tip_r;
  mac_t    res_rmac_r;

  logic                    out_valid_r;
  logic [OUT_FIELDS_W-1:0] out_data_r;

  cache_req_t req_r;
  cache_rsp_t rsp;

  logic is_learn;
  logic fmt_ok;
  logic on_link;
  ip_t  hop;

  assign is_learn = (oper_r == ARP_OPER_REQUEST) || (oper_r == ARP_OPER_REPLY);
  assign fmt_ok   = (htype_r == ARP_HTYPE_ETH) && (ptype_r == ARP_PTYPE_IPV4) &&
                    (hlen_r == ARP_HLEN_ETH) && (plen_r == ARP_PLEN_IPV4);
  assign on_link  = (own_ip_r != '0) &&
                    ((own_ip_r & subnet_mask_r) == (lookup_ip_r & subnet_mask_r));
  assign hop      = on_link ? lookup_ip_r : gateway_ip_r;

  assign in_tready  = (state_r == T_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r      <= '0;
      subnet_mask_r <= '0;
      gateway_ip_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OWN_IP:      own_ip_r      <= cfg_wdata[IP_W-1:0];
        REG_SUBNET_MASK: subnet_mask_r <= cfg_wdata[IP_W-1:0];
        REG_GATEWAY_IP:  gateway_ip_r  <= cfg_wdata[IP_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture, payload only
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r        <= in_tuser;
      oper_r        <= in_tdata[15:0];
      htype_r       <= in_tdata[31:16];
      ptype_r       <= in_tdata[47:32];
      hlen_r        <= in_tdata[55:48];
      plen_r        <= in_tdata[63:56];
      sender_mac_r  <= in_tdata[111:64];
      sender_ip_r   <= in_tdata[143:112];
      target_ip_r   <= in_tdata[175:144];
      eth_src_mac_r <= in_tdata[223:176];
      lookup_ip_r   <= in_tdata[255:224];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      req_r        <= '0;
      hop_r        <= '0;
      res_action_r <= ACT_ABSORB;
      res_fop_r    <= FOP_NONE;
      res_tmac_r   <= '0;
      res_tip_r    <= '0;
      res_rmac_r   <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      req_r.start <= 1'b0;
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (in_tvalid) begin
            state_r <= T_DECODE;
          end
        end
        T_DECODE: begin
          res_action_r <= ACT_ABSORB;
          res_fop_r    <= FOP_NONE;
          res_tmac_r   <= '0;
          res_tip_r    <= '0;
          res_rmac_r   <= '0;
          if (!kind_r) begin
            if (oper_r == ARP_OPER_REQUEST) begin
              if (!fmt_ok) begin
                res_action_r <= ACT_UNSUP;
              end else if ((own_ip_r != '0) && (target_ip_r == own_ip_r)) begin
                res_action_r <= ACT_REPLY;
                res_fop_r    <= FOP_REPLY;
                res_tmac_r   <= sender_mac_r;
                res_tip_r    <= sender_ip_r;
              end
            end
            if (is_learn) begin
              req_r   <= '{start: 1'b1, learn: 1'b1, key: sender_ip_r, mac: eth_src_mac_r};
              state_r <= T_WAIT;
            end else begin
              state_r <= T_EMIT;
            end
          end else begin
            hop_r   <= hop;
            req_r   <= '{start: 1'b1, learn: 1'b0, key: hop, mac: '0};
            state_r <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (rsp.done) begin
            if (kind_r) begin
              if (rsp.hit) begin
                res_action_r <= ACT_HIT;
                res_rmac_r   <= rsp.mac;
              end else begin
                res_action_r <= ACT_MISS;
                res_fop_r    <= FOP_QUERY;
                res_tip_r    <= hop_r;
              end
            end
            state_r <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {res_rmac_r, res_tip_r, res_tmac_r, res_fop_r, res_action_r};
            state_r     <= T_IDLE;
          end
        end
        default: begin
          state_r <= T_IDLE;
        end
      endcase
    end
  end

  arc_cache #(
    .CACHE_ENTRIES(CACHE_ENTRIES)
  ) u_cache (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req_r),
    .rsp  (rsp)
  );

`ifndef NO_ASSERTIONS
  a_rsp_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == T_WAIT))
    else $error("cache response outside wait state");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == T_DECODE))
    else $error("accepted transaction not decoded");

  a_reply_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[2:0] == ACT_REPLY)) |-> (out_data_r[4:3] == FOP_REPLY))
    else $error("reply result without reply frame");

  a_start_decode: assert property (@(posedge clk) disable iff (!rst_n)
    req_r.start |-> ($past(state_r) == T_DECODE))
    else $error("cache started outside decode");
`endif

endmodule
